@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the date block.
// Each check samples on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check held only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check held at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dad_pkg.sv @@
// ----------------------------------------------------------------------------
// dad_pkg
// Widths, calendar constants, sequencer states and the month length table.
// ----------------------------------------------------------------------------
package dad_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 16;
	localparam int COUNT_W = 16;
	localparam int SUM_W   = 17;
	localparam int LEN_W   = 5;

	// Year reduction: subtract 400 << k for k = REDUCE_STEPS-1 down to 0
	localparam int REDUCE_STEPS = 8;
	localparam int STEP_W       = 3;

	localparam logic [SUM_W-1:0]  YEAR_CYCLE   = 17'd400;
	localparam logic [YEAR_W-1:0] CYCLE_LAST   = 16'd399;
	localparam logic [YEAR_W-1:0] CENTURY      = 16'd100;
	localparam logic [YEAR_W-1:0] CENTURY_2    = 16'd200;
	localparam logic [YEAR_W-1:0] CENTURY_3    = 16'd300;
	localparam logic [YEAR_W-1:0] YEAR_MAX     = 16'hFFFF;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [LEN_W-1:0] LEN_31   = 5'd31;
	localparam logic [LEN_W-1:0] LEN_30   = 5'd30;
	localparam logic [LEN_W-1:0] LEN_LEAP = 5'd29;
	localparam logic [LEN_W-1:0] LEN_FEB  = 5'd28;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_WALK
	} state_t;

	// Leap test on the year taken modulo 400
	function automatic logic is_leap(input logic [YEAR_W-1:0] r);
		return (r[1:0] == 2'b00) && (r != CENTURY) && (r != CENTURY_2) && (r != CENTURY_3);
	endfunction

	// Days in month m; odd/even pattern flips after July
	function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
	                                              input logic leap);
		logic [LEN_W-1:0] len;
		if (m == MONTH_FEB) begin
			len = leap ? LEN_LEAP : LEN_FEB;
		end else if (m <= MONTH_JUL) begin
			len = m[0] ? LEN_31 : LEN_30;
		end else begin
			len = m[0] ? LEN_30 : LEN_31;
		end
		return len;
	endfunction

endpackage

@@ hdl/dad_in_if.sv @@
// ----------------------------------------------------------------------------
// dad_in_if
// Request channel: starting date and day count.
// ----------------------------------------------------------------------------
interface dad_in_if import dad_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [DAY_W-1:0]    day;
	logic [MONTH_W-1:0]  month;
	logic [YEAR_W-1:0]   year;
	logic [COUNT_W-1:0]  add_days;

	modport source (output valid, day, month, year, add_days, input ready);
	modport sink   (input valid, day, month, year, add_days, output ready);

endinterface

@@ hdl/dad_out_if.sv @@
// ----------------------------------------------------------------------------
// dad_out_if
// Result channel: advanced date and year wrap flag.
// ----------------------------------------------------------------------------
interface dad_out_if import dad_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [DAY_W-1:0]    new_day;
	logic [MONTH_W-1:0]  new_month;
	logic [YEAR_W-1:0]   new_year;
	logic                year_overflow;

	modport source (output valid, new_day, new_month, new_year, year_overflow, input ready);
	modport sink   (input valid, new_day, new_month, new_year, year_overflow, output ready);

endinterface

@@ hdl/date_add_days_core.sv @@
// ----------------------------------------------------------------------------
// date_add_days_core
// Advances a Gregorian date by a day count, one month per cycle.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                    | handshake
//  date_in   | in  | day, month, year, add_days                 | valid/ready
//  date_out  | out | new_day, new_month, new_year, year_overflow | valid/ready
//
// A request first reduces the year modulo 400, then has one month length
// subtracted per cycle, both on the one 17-bit compare/subtract unit.
// date_in.ready is high only while idle. Reset clears the sequencer and
// the result valid flag; no memory to clear. A stalled result holds in the
// output register and the last walk cycle waits until that register frees.
module date_add_days_core import dad_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	dad_in_if.sink         date_in,
	dad_out_if.source      date_out
);

	`include "assert_macros.svh"

	state_t               state_q, state_d;
	logic [STEP_W-1:0]    k_q;
	logic [SUM_W-1:0]     day_q;
	logic [MONTH_W-1:0]   month_q;
	logic [YEAR_W-1:0]    year_q;
	logic [YEAR_W-1:0]    rem_q;
	logic                 ovf_q;
	logic                 out_valid_q;
	logic [DAY_W-1:0]     new_day_q;
	logic [MONTH_W-1:0]   new_month_q;
	logic [YEAR_W-1:0]    new_year_q;
	logic                 new_ovf_q;

	logic                 accept;
	logic                 slot_free;
	logic [LEN_W-1:0]     len;
	logic [SUM_W-1:0]     op_a, op_b;
	logic [SUM_W:0]       diff;
	logic                 a_ge_b, a_gt_b;
	logic                 step_month, finish;

	// Take a request only while idle
	assign date_in.ready = (state_q == ST_IDLE);

	assign accept    = date_in.valid && date_in.ready;
	assign slot_free = !out_valid_q || date_out.ready;
	assign len       = month_len(month_q, is_leap(rem_q));

	// Shared compare/subtract unit
	always_comb begin
		if (state_q == ST_REDUCE) begin
			op_a = {1'b0, rem_q};
			op_b = YEAR_CYCLE << k_q;
		end else begin
			op_a = day_q;
			op_b = {{(SUM_W-LEN_W){1'b0}}, len};
		end
		diff   = {1'b0, op_a} - {1'b0, op_b};
		a_ge_b = !diff[SUM_W];
		a_gt_b = a_ge_b && (diff[SUM_W-1:0] != '0);
	end

	// Next state and step controls
	always_comb begin
		state_d    = state_q;
		step_month = 1'b0;
		finish     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (k_q == '0) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (a_gt_b) begin
					step_month = 1'b1;
				end else if (slot_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				k_q <= STEP_W'(REDUCE_STEPS - 1);
			end else if (state_q == ST_REDUCE) begin
				k_q <= k_q - 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (date_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working date: load, reduce year, advance months
	always_ff @(posedge clk) begin
		if (accept) begin
			day_q   <= SUM_W'(date_in.day) + SUM_W'(date_in.add_days);
			month_q <= date_in.month;
			year_q  <= date_in.year;
			rem_q   <= date_in.year;
			ovf_q   <= 1'b0;
		end else if (state_q == ST_REDUCE) begin
			if (a_ge_b) rem_q <= diff[YEAR_W-1:0];
		end else if (step_month) begin
			day_q <= diff[SUM_W-1:0];
			if (month_q >= MONTH_DEC) begin
				month_q <= MONTH_JAN;
				year_q  <= year_q + 1'b1;
				if (year_q == YEAR_MAX) begin
					rem_q <= '0;
					ovf_q <= 1'b1;
				end else if (rem_q == CYCLE_LAST) begin
					rem_q <= '0;
				end else begin
					rem_q <= rem_q + 1'b1;
				end
			end else begin
				month_q <= month_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (finish) begin
			new_day_q   <= day_q[DAY_W-1:0];
			new_month_q <= month_q;
			new_year_q  <= year_q;
			new_ovf_q   <= ovf_q;
		end
	end

	assign date_out.valid         = out_valid_q;
	assign date_out.new_day       = new_day_q;
	assign date_out.new_month     = new_month_q;
	assign date_out.new_year      = new_year_q;
	assign date_out.year_overflow = new_ovf_q;

	`ASSERT_CLK(a_accept_reduce, accept |=> state_q == ST_REDUCE, "request did not start reduction")
	`ASSERT_CLK(a_rem_range, state_q == ST_WALK |-> rem_q <= CYCLE_LAST, "year remainder out of range")
	`ASSERT_CLK(a_valid_from_walk, $rose(out_valid_q) |-> $past(state_q) == ST_WALK, "result without walk")
	`ASSERT_CLK(a_walk_day_fits, finish |-> day_q[SUM_W-1:DAY_W] == '0, "final day too wide")
	`ASSERT_ALWAYS(a_reset_idle, !arst_n |-> state_q == ST_IDLE && !out_valid_q, "not idle in reset")

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives date_add_days_core with dated requests over valid/ready channels and
// checks every result against a calendar predictor kept inside the bench.
// The stimulus covers calendar corners, random traffic under several idling
// mixes, and a long result stall that backs the block up to its input.
// ----------------------------------------------------------------------------
module testbench;
	import dad_pkg::*;

	localparam int HALF_PERIOD      = 5;
	localparam int RESET_CYCLES     = 7;
	localparam int RANDOM_PER_PHASE = 60;
	localparam int HOLD_CYCLES      = 400;
	localparam int TAIL_CYCLES      = 2300;
	localparam int RUN_LIMIT_NS     = 40_000_000;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [COUNT_W-1:0] add_days;
	} date_req_t;

	typedef struct packed {
		logic [DAY_W-1:0]   new_day;
		logic [MONTH_W-1:0] new_month;
		logic [YEAR_W-1:0]  new_year;
		logic               year_overflow;
	} date_res_t;

	logic clk = 1'b0;
	logic arst_n;

	dad_in_if  date_in ();
	dad_out_if date_out ();

	date_add_days_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.date_in  (date_in),
		.date_out (date_out)
	);

	date_res_t pending_dates[$];
	int        error_count    = 0;
	int        send_idle_pct  = 0;
	int        sink_stall_pct = 0;
	logic      hold_active    = 1'b0;
	event      hold_go;

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------
	function automatic bit leap_year(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// Month 0 and 13..15 fall through the same odd/even rule
	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		if (m == 2)
			return leap_year(y) ? 29 : 28;
		if (m <= 7)
			return (m % 2) ? 31 : 30;
		return (m % 2) ? 30 : 31;
	endfunction

	function automatic date_res_t advance_date(input date_req_t r);
		int unsigned d;
		int unsigned m;
		int unsigned y;
		int unsigned len;
		date_res_t   res;
		d   = r.day + r.add_days;
		m   = r.month;
		y   = r.year;
		res = '0;
		len = days_in_month(m, y);
		// walk a month at a time, rolling the year past December
		while (d > len) begin
			d -= len;
			m += 1;
			if (m > 12) begin
				m = 1;
				y += 1;
				if (y > 16'hFFFF) begin
					y = 0;
					res.year_overflow = 1'b1;
				end
			end
			len = days_in_month(m, y);
		end
		res.new_day   = DAY_W'(d);
		res.new_month = MONTH_W'(m);
		res.new_year  = YEAR_W'(y);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request generation and sending
	// ------------------------------------------------------------------
	function automatic date_req_t random_date();
		date_req_t   r;
		int unsigned pick;
		pick       = $urandom_range(99);
		r.day      = DAY_W'($urandom_range(31));
		r.month    = MONTH_W'($urandom_range(15));
		r.year     = YEAR_W'($urandom_range(16'hFFFF));
		r.add_days = COUNT_W'($urandom_range(16'hFFFF));
		// noise: any field value, malformed dates included
		if (pick < 12)
			return r;
		if (pick < 24)
			r.year = YEAR_W'(16'hFFFF - $urandom_range(3));
		else if (pick < 36)
			r.year = YEAR_W'(100 * $urandom_range(655));
		r.month = MONTH_W'($urandom_range(12, 1));
		r.day   = DAY_W'($urandom_range(days_in_month(r.month, r.year), 1));
		// keep most walks short, a few span the full count
		if (pick % 11 != 0)
			r.add_days = COUNT_W'($urandom_range(1500));
		return r;
	endfunction

	// Offer one request, hold it until taken, then log its expected result
	task automatic send_date(input date_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			date_in.valid <= 1'b0;
			@(posedge clk);
		end
		date_in.valid    <= 1'b1;
		date_in.day      <= r.day;
		date_in.month    <= r.month;
		date_in.year     <= r.year;
		date_in.add_days <= r.add_days;
		do
			@(posedge clk);
		while (!date_in.ready);
		pending_dates.push_back(advance_date(r));
	endtask

	task automatic send_fields(input int unsigned d, input int unsigned m,
	                           input int unsigned y, input int unsigned n);
		date_req_t r;
		r.day      = DAY_W'(d);
		r.month    = MONTH_W'(m);
		r.year     = YEAR_W'(y);
		r.add_days = COUNT_W'(n);
		send_date(r);
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		date_res_t want;
		string     bad;
		if (arst_n === 1'b1 && date_out.valid === 1'b1 && date_out.ready === 1'b1) begin
			if (pending_dates.size() == 0) begin
				report_mismatch($sformatf("result with no request outstanding: %0d/%0d/%0d ovf %0b",
					date_out.new_day, date_out.new_month, date_out.new_year,
					date_out.year_overflow));
			end else begin
				want = pending_dates.pop_front();
				bad  = "";
				if (date_out.new_day !== want.new_day)
					bad = {bad, " new_day"};
				if (date_out.new_month !== want.new_month)
					bad = {bad, " new_month"};
				if (date_out.new_year !== want.new_year)
					bad = {bad, " new_year"};
				if (date_out.year_overflow !== want.year_overflow)
					bad = {bad, " year_overflow"};
				if (bad != "")
					report_mismatch($sformatf("wrong%s: got %0d/%0d/%0d ovf %0b, want %0d/%0d/%0d ovf %0b",
						bad, date_out.new_day, date_out.new_month, date_out.new_year,
						date_out.year_overflow, want.new_day, want.new_month, want.new_year,
						want.year_overflow));
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, plus a long hold on demand
	// ------------------------------------------------------------------
	initial begin
		date_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			date_out.ready <= !hold_active && ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Count out the long hold in cycles
	initial begin
		forever begin
			@(hold_go);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		send_idle_pct   = 0;
		sink_stall_pct <= 0;
		// day zero kept, all-zero request
		send_fields(0, 1, 2000, 0);
		send_fields(0, 0, 0, 0);
		// year wrap, single step and full count
		send_fields(31, 12, 16'hFFFF, 1);
		send_fields(31, 12, 16'hFFFF, 16'hFFFF);
		send_fields(31, 15, 16'hFFFF, 16'hFFFF);
		// leap rules: 400, 100 and 4; year zero counts as leap
		send_fields(29, 2, 2000, 0);
		send_fields(29, 2, 1900, 0);
		send_fields(28, 2, 2024, 1);
		send_fields(1, 1, 0, 366);
		send_fields(1, 1, 2100, 59);
		// month zero stepping on
		send_fields(1, 0, 2023, 30);
		// months past December: short ones roll, month 14 holds 31
		send_fields(31, 14, 500, 0);
		send_fields(20, 15, 16'hFFFF, 11);
		// starting day past the month end, no days added
		send_fields(31, 4, 2021, 0);
		// every month code, one day added to a start day of 28 to 31
		for (int m = 0; m < 16; m++)
			send_fields(28 + m % 4, m, 1996 + m, 1);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct   = idle_pct;
		sink_stall_pct <= stall_pct;
		repeat (count)
			send_date(random_date());
	endtask

	// Stall the result side long enough for requests to pile up at the input
	task automatic test_backpressure();
		date_req_t r;
		send_idle_pct   = 0;
		sink_stall_pct <= 0;
		-> hold_go;
		repeat (6) begin
			r.month    = MONTH_W'($urandom_range(12, 1));
			r.year     = YEAR_W'($urandom_range(16'hFFFF));
			r.day      = DAY_W'($urandom_range(28, 1));
			r.add_days = COUNT_W'($urandom_range(40));
			send_date(r);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n           <= 1'b0;
		date_in.valid    <= 1'b0;
		date_in.day      <= '0;
		date_in.month    <= '0;
		date_in.year     <= '0;
		date_in.add_days <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(0, 0, RANDOM_PER_PHASE);
		test_random_traffic(49, 0, RANDOM_PER_PHASE);
		test_backpressure();
		test_random_traffic(0, 49, RANDOM_PER_PHASE);
		test_random_traffic(29, 29, RANDOM_PER_PHASE);
		date_in.valid <= 1'b0;

		// drain, then watch for stray results
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#(RUN_LIMIT_NS);
		$display("TIMEOUT: %0d results still outstanding", pending_dates.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
